// ===== design/assert_macros.svh =====
// assertion macros used by the go-to-goal controller top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/g2g_pkg.sv =====
// shared constants, types and tables for the go-to-goal controller
`default_nettype none
package g2g_pkg;
  localparam int CordicStages = 16;
  localparam int AngW = 40;
  localparam logic signed [AngW-1:0] PiQ = 40'sd205887;
  localparam logic signed [AngW-1:0] HalfPiQ = 40'sd102944;
  localparam logic signed [AngW-1:0] TwoPiQ = 40'sd411775;

  localparam logic [2:0] RegGoalX = 3'd0;
  localparam logic [2:0] RegGoalY = 3'd1;
  localparam logic [2:0] RegLinGain = 3'd2;
  localparam logic [2:0] RegAngGain = 3'd3;
  localparam logic [2:0] RegMaxLin = 3'd4;
  localparam logic [2:0] RegMaxAng = 3'd5;
  localparam logic [2:0] RegNearRad = 3'd6;

  // cordic vector width: 34 bit operand scaled by 2^16 plus growth
  localparam int CorW = 54;

  typedef struct packed {
    logic signed [CorW-1:0] x;
    logic signed [CorW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } cor_t;

  function automatic logic signed [AngW-1:0] atan_q(input int i);
    logic signed [AngW-1:0] r;
    begin
      case (i)
        0: r = 40'sd51472; 1: r = 40'sd30386; 2: r = 40'sd16055; 3: r = 40'sd8150;
        4: r = 40'sd4091;  5: r = 40'sd2047;  6: r = 40'sd1024;  7: r = 40'sd512;
        8: r = 40'sd256;   9: r = 40'sd128;  10: r = 40'sd64;   11: r = 40'sd32;
        12: r = 40'sd16;  13: r = 40'sd8;    14: r = 40'sd4;    15: r = 40'sd2;
        16: r = 40'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [AngW-1:0] wrap1(input logic signed [AngW-1:0] a);
    logic signed [AngW-1:0] r;
    begin
      if (a <= -PiQ) r = a + TwoPiQ;
      else if (a >= PiQ) r = a - TwoPiQ;
      else r = a;
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== design/g2g_cordic.sv =====
// pipelined cordic vectoring unit, one stage per iteration, stall aware
`default_nettype none
module g2g_cordic (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [33:0]          vec_y,
  input  wire logic signed [33:0]          vec_x,
  output      logic signed [g2g_pkg::AngW-1:0] angle
);
  import g2g_pkg::*;

  cor_t stg [CordicStages+1];
  cor_t nx [CordicStages];
  cor_t pre;
  logic signed [CorW-1:0] xs0, ys0;

  always_comb begin
    xs0 = {{(CorW-50){vec_x[33]}}, vec_x, 16'd0};
    ys0 = {{(CorW-50){vec_y[33]}}, vec_y, 16'd0};
    pre.zero = (vec_x == '0) && (vec_y == '0);
    if (vec_x < 0) begin
      pre.z = (vec_y >= 0) ? PiQ : -PiQ;
      pre.x = -xs0;
      pre.y = -ys0;
    end else begin
      pre.z = '0;
      pre.x = xs0;
      pre.y = ys0;
    end
  end

  // one micro-rotation per stage
  always_comb begin
    for (int i = 0; i < CordicStages; i++) begin
      nx[i] = stg[i];
      if (stg[i].y >= 0) begin
        nx[i].x = stg[i].x + (stg[i].y >>> i);
        nx[i].y = stg[i].y - (stg[i].x >>> i);
        nx[i].z = stg[i].z + atan_q(i);
      end else begin
        nx[i].x = stg[i].x - (stg[i].y >>> i);
        nx[i].y = stg[i].y + (stg[i].x >>> i);
        nx[i].z = stg[i].z - atan_q(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= pre;
      for (int i = 0; i < CordicStages; i++) begin
        stg[i+1] <= nx[i];
      end
    end
  end

  assign angle = stg[CordicStages].zero ? '0 : stg[CordicStages].z;
endmodule
`default_nettype wire

// ===== design/go_to_goal_p_controller.sv =====
// top level of the go-to-goal proportional controller
// One pose item enters per cycle while in_stall is low. Stages in order:
// quaternion products and goal differences, yaw terms, the cordic
// pipeline for yaw and bearing side by side (16 cordic stages by
// default), then wrap, gain multiply, clamp and output. The whole pipe
// advances together; a stall freezes every stage, so in_stall equals
// out_stall while the output holds an item. Configuration writes are
// always ready; goal writes apply to later items, other registers to
// items in flight too; they are meant to be made while idle.
`default_nettype none
`include "assert_macros.svh"
module go_to_goal_p_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  input  wire logic signed [15:0] quat_w,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [17:0] lin_cmd,
  output      logic signed [17:0] ang_cmd,
  output      logic               near_goal,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import g2g_pkg::*;

  localparam int Lat = CordicStages + 6;

  // configuration registers
  logic signed [31:0] goal_x, goal_y;
  logic [15:0] lin_gain, ang_gain;
  logic [16:0] max_lin, max_ang, near_rad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0; goal_y <= '0;
      lin_gain <= 16'd3277; ang_gain <= 16'd2048;
      max_lin <= 17'd9830; max_ang <= 17'd3277; near_rad <= 17'd13107;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegGoalX:   goal_x <= cfg_data;
        RegGoalY:   goal_y <= cfg_data;
        RegLinGain: lin_gain <= cfg_data[15:0];
        RegAngGain: ang_gain <= cfg_data[15:0];
        RegMaxLin:  max_lin <= cfg_data[16:0];
        RegMaxAng:  max_ang <= cfg_data[16:0];
        RegNearRad: near_rad <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves unless the output holds an item that is stalled
  logic en;
  logic [Lat-1:0] vld;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_valid};
  end
  assign out_valid = vld[Lat-1];

  // stage 1: products and differences
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [32:0] s1_dx, s1_dy;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wz <= 32'(quat_w * quat_z);
      p_xy <= 32'(quat_x * quat_y);
      p_yy <= 32'(quat_y * quat_y);
      p_zz <= 32'(quat_z * quat_z);
      s1_dx <= 33'(goal_x) - 33'(pos_x);
      s1_dy <= 33'(goal_y) - 33'(pos_y);
    end
  end

  // stage 2: yaw vector terms, squared distance operands
  logic signed [33:0] s2_num, s2_den, s2_dx, s2_dy;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_num <= 34'(p_wz) * 2 + 34'(p_xy) * 2;
      s2_den <= 34'sd268435456 - (34'(p_yy) * 2 + 34'(p_zz) * 2);
      s2_dx <= 34'(s1_dx);
      s2_dy <= 34'(s1_dy);
    end
  end

  logic signed [AngW-1:0] yaw_raw, brg_raw;
  g2g_cordic u_yaw (.clk, .en, .vec_y(s2_num), .vec_x(s2_den), .angle(yaw_raw));
  g2g_cordic u_brg (.clk, .en, .vec_y(s2_dy), .vec_x(s2_dx), .angle(brg_raw));

  // delay line for dx/dy alongside the cordic
  logic signed [33:0] dl_dx [CordicStages+1];
  logic signed [33:0] dl_dy [CordicStages+1];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_dx[0] <= s2_dx;
      dl_dy[0] <= s2_dy;
      for (int k = 0; k < CordicStages; k++) begin
        dl_dx[k+1] <= dl_dx[k];
        dl_dy[k+1] <= dl_dy[k];
      end
    end
  end
  logic signed [33:0] c_dx, c_dy;
  assign c_dx = dl_dx[CordicStages];
  assign c_dy = dl_dy[CordicStages];

  // stage A: wrap angles, heading error; squares of distance
  logic signed [AngW-1:0] a_err;
  logic signed [33:0] a_dx;
  logic a_small;
  logic [35:0] a_dx2, a_dy2;
  logic [33:0] r2;
  logic signed [AngW-1:0] diff;
  logic signed [17:0] dxs, dys;
  always_comb begin
    diff = wrap1(wrap1(brg_raw)) - wrap1(wrap1(yaw_raw));
    dxs = c_dx[17:0];
    dys = c_dy[17:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_err <= wrap1(wrap1(diff));
      a_dx <= c_dx;
      a_small <= (c_dx < 34'sd131072) && (c_dx > -34'sd131072)
              && (c_dy < 34'sd131072) && (c_dy > -34'sd131072);
      a_dx2 <= 36'(dxs * dxs);
      a_dy2 <= 36'(dys * dys);
      r2 <= 34'(near_rad * near_rad);
    end
  end

  // stage B: gain products, near compare
  logic signed [57:0] b_w, b_v;
  logic b_flip, b_near;
  always_ff @(posedge clk) begin
    if (en) begin
      b_w <= 58'(a_err * $signed({1'b0, ang_gain})) + 58'sd2048;
      b_v <= 58'(a_dx * $signed({1'b0, lin_gain})) + 58'sd2048;
      b_flip <= (a_err > HalfPiQ) || (a_err < -HalfPiQ);
      b_near <= a_small && ((37'(a_dx2) + 37'(a_dy2)) < 37'(r2));
    end
  end

  // stage C: shift, sign flip, clamp, near forcing
  logic signed [45:0] w_s, v_s, w_c, v_c;
  logic signed [45:0] lim_w, lim_v;
  always_comb begin
    w_s = 46'(b_w >>> 12);
    v_s = 46'(b_v >>> 12);
    if (b_flip) w_s = -w_s;
    lim_w = 46'(max_ang);
    lim_v = 46'(max_lin);
    w_c = (w_s > lim_w) ? lim_w : ((w_s < -lim_w) ? -lim_w : w_s);
    v_c = (v_s > lim_v) ? lim_v : ((v_s < -lim_v) ? -lim_v : v_s);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lin_cmd <= b_near ? '0 : v_c[17:0];
      ang_cmd <= b_near ? '0 : w_c[17:0];
      near_goal <= b_near;
    end
  end

  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(lin_cmd), "stalled item changed")
  `ASSERT_CLK(a_near_zero, clk, rst, !(out_valid && near_goal) || (lin_cmd == '0 && ang_cmd == '0), "near item not zero")
  `ASSERT_CLK(a_stall_link, clk, rst, in_stall == (out_valid && out_stall), "pipe stall mismatch")
endmodule
`default_nettype wire
